/* rtl/cle_pkg.sv */
package cle_pkg;

  // Largest number of peers that the vote map can track.
  localparam int MAX_PEERS = 8;
  // Wide enough for the capped peer count and for a vote total of all peers plus self.
  localparam int CNT_W = $clog2(MAX_PEERS + 2);

  // Request types.
  localparam logic [2:0] REQ_TICK        = 3'd0;
  localparam logic [2:0] REQ_VOTE        = 3'd1;
  localparam logic [2:0] REQ_APPEND      = 3'd2;
  localparam logic [2:0] REQ_VOTE_REPLY  = 3'd3;
  localparam logic [2:0] REQ_APPEND_REPLY = 3'd4;

  // Reply kinds.
  localparam logic [1:0] REPLY_NONE   = 2'd0;
  localparam logic [1:0] REPLY_VOTE   = 2'd1;
  localparam logic [1:0] REPLY_APPEND = 2'd2;

  // Broadcast kinds.
  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_VOTE = 2'd1;
  localparam logic [1:0] SEND_BEAT = 2'd2;

  // Node roles.
  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SELF_NODE  = 3'd0;
  localparam logic [2:0] CFG_PEER_COUNT = 3'd1;
  localparam logic [2:0] CFG_ELECT_MIN  = 3'd2;
  localparam logic [2:0] CFG_ELECT_MAX  = 3'd3;
  localparam logic [2:0] CFG_HEARTBEAT  = 3'd4;

  localparam logic [31:0] TERM_TOP = 32'hFFFF_FFFF;
  localparam logic [15:0] BEAT_TOP = 16'hFFFF;

  typedef logic [MAX_PEERS-1:0] peer_map_t;

  typedef struct packed {
    logic [7:0]  self_node;
    logic [3:0]  peer_count;
    logic [15:0] election_min_ticks;
    logic [15:0] election_max_ticks;
    logic [15:0] heartbeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] msg_term;
    logic [7:0]  sender_node;
    logic [2:0]  peer_slot;
    logic [31:0] asked_term;
    logic        granted_flag;
    logic [15:0] jitter;
  } item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [31:0] answer_term;
    logic        reply_ok;
    logic [1:0]  send_kind;
    logic [31:0] send_term;
    logic [1:0]  node_role;
    logic [31:0] term_now;
    logic        leader_known;
    logic [7:0]  leader_node;
  } result_t;

endpackage

/* rtl/cle_req_if.sv */
interface cle_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] msg_term;
  logic [7:0]  sender_node;
  logic [2:0]  peer_slot;
  logic [31:0] asked_term;
  logic        granted_flag;
  logic [15:0] jitter;

  modport source (
    output valid, req_type, msg_term, sender_node, peer_slot, asked_term,
      granted_flag, jitter,
    input  ready
  );
  modport sink (
    input  valid, req_type, msg_term, sender_node, peer_slot, asked_term,
      granted_flag, jitter,
    output ready
  );
endinterface

/* rtl/cle_res_if.sv */
interface cle_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [31:0] answer_term;
  logic        reply_ok;
  logic [1:0]  send_kind;
  logic [31:0] send_term;
  logic [1:0]  node_role;
  logic [31:0] term_now;
  logic        leader_known;
  logic [7:0]  leader_node;

  modport source (
    output valid, reply_kind, answer_term, reply_ok, send_kind, send_term,
      node_role, term_now, leader_known, leader_node,
    input  ready
  );
  modport sink (
    input  valid, reply_kind, answer_term, reply_ok, send_kind, send_term,
      node_role, term_now, leader_known, leader_node,
    output ready
  );
endinterface

/* rtl/consensus_leader_election.sv */
// Leader election for one consensus node. Each accepted request (a tick, a
// vote or append request from another node, or a reply to one of this
// node's broadcasts) produces exactly one result carrying the reply, the
// broadcast to send and the node status afterwards. The block takes one
// request per clock cycle while its results are taken: a request passes an
// input register, the election logic and a result register, which holds its
// result until it is taken. While a result waits to be taken, the input
// register holds one more request and the input then stalls until the
// result is taken. Configuration writes take effect at once and are meant
// for times when no request is in flight.
module consensus_leader_election (
  input  logic        clk,
  input  logic        rst_n,
  cle_req_if.sink     in_req,
  cle_res_if.source   out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cle_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t res;
  result_t res_r;
  logic    res_valid_r;
  logic    out_free;
  logic    step;

  cle_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cle_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  // Handshake: a request moves on whenever the result register can take it.
  assign out_free     = !res_valid_r || out_res.ready;
  assign step         = item_valid_r && out_free;
  assign in_req.ready = !item_valid_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      item_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      item_r.req_type     <= in_req.req_type;
      item_r.msg_term     <= in_req.msg_term;
      item_r.sender_node  <= in_req.sender_node;
      item_r.peer_slot    <= in_req.peer_slot;
      item_r.asked_term   <= in_req.asked_term;
      item_r.granted_flag <= in_req.granted_flag;
      item_r.jitter       <= in_req.jitter;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_free) begin
      res_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_res.valid        = res_valid_r;
  assign out_res.reply_kind   = res_r.reply_kind;
  assign out_res.answer_term  = res_r.answer_term;
  assign out_res.reply_ok     = res_r.reply_ok;
  assign out_res.send_kind    = res_r.send_kind;
  assign out_res.send_term    = res_r.send_term;
  assign out_res.node_role    = res_r.node_role;
  assign out_res.term_now     = res_r.term_now;
  assign out_res.leader_known = res_r.leader_known;
  assign out_res.leader_node  = res_r.leader_node;

  // A result without a reply carries no reply term or grant.
  a_no_reply_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.reply_kind == REPLY_NONE |->
      res_r.answer_term == 32'd0 && !res_r.reply_ok)
    else $error("reply fields set on a result without a reply");

endmodule

/* rtl/cle_cfg.sv */
module cle_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output cle_pkg::cfg_t cfg
);
  import cle_pkg::*;

  cfg_t cfg_r;

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_node          <= 8'd0;
      cfg_r.peer_count         <= 4'd2;
      cfg_r.election_min_ticks <= 16'd8;
      cfg_r.election_max_ticks <= 16'd15;
      cfg_r.heartbeat_ticks    <= 16'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELF_NODE:  cfg_r.self_node          <= cfg_data[7:0];
        CFG_PEER_COUNT: cfg_r.peer_count         <= cfg_data[3:0];
        CFG_ELECT_MIN:  cfg_r.election_min_ticks <= cfg_data;
        CFG_ELECT_MAX:  cfg_r.election_max_ticks <= cfg_data;
        CFG_HEARTBEAT:  cfg_r.heartbeat_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/cle_engine.sv */
module cle_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  cle_pkg::cfg_t    cfg,
  input  logic             step,
  input  cle_pkg::item_t   item,
  output cle_pkg::result_t res
);
  import cle_pkg::*;

  logic [1:0]       role_r, role_nxt;
  logic [31:0]      term_r, term_nxt;
  logic             vote_valid_r, vote_valid_nxt;
  logic [7:0]       vote_node_r, vote_node_nxt;
  logic             leader_valid_r, leader_valid_nxt;
  logic [7:0]       leader_node_r, leader_node_nxt;
  logic [15:0]      elect_left_r, elect_left_nxt;
  logic [15:0]      beat_r, beat_nxt;
  peer_map_t        votes_r, votes_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;

  logic [CNT_W-1:0] peers_used;
  logic [CNT_W:0]   peers_inc;
  logic [CNT_W-1:0] majority;
  logic [16:0]      timeout_sum;
  logic [15:0]      timeout;
  peer_map_t        slot_bit;
  logic             slot_in_range;

  // Election timeout: minimum plus jitter, capped at the maximum.
  always_comb begin
    timeout_sum = {1'b0, cfg.election_min_ticks} + {1'b0, item.jitter};
    if (timeout_sum > {1'b0, cfg.election_max_ticks}) begin
      timeout = cfg.election_max_ticks;
    end else begin
      timeout = timeout_sum[15:0];
    end
  end

  // Effective peer count, majority and the map bit of the replying peer.
  always_comb begin
    if (32'(cfg.peer_count) > MAX_PEERS) begin
      peers_used = CNT_W'(MAX_PEERS);
    end else begin
      peers_used = CNT_W'(cfg.peer_count);
    end
    peers_inc     = {1'b0, peers_used} + (CNT_W+1)'(1);
    majority      = CNT_W'(peers_inc >> 1) + CNT_W'(1);
    slot_bit      = peer_map_t'(1) << item.peer_slot;
    slot_in_range = 32'(item.peer_slot) < 32'(peers_used);
  end

  // Request handling: next state and the result for this request.
  always_comb begin
    role_nxt         = role_r;
    term_nxt         = term_r;
    vote_valid_nxt   = vote_valid_r;
    vote_node_nxt    = vote_node_r;
    leader_valid_nxt = leader_valid_r;
    leader_node_nxt  = leader_node_r;
    elect_left_nxt   = elect_left_r;
    beat_nxt         = beat_r;
    votes_nxt        = votes_r;
    total_nxt        = total_r;
    res              = '0;

    case (item.req_type)
      REQ_TICK: begin
        if (role_r == ROLE_LEADER) begin
          if (beat_r != BEAT_TOP) begin
            beat_nxt = beat_r + 16'd1;
          end
          if (beat_nxt >= cfg.heartbeat_ticks) begin
            beat_nxt      = 16'd0;
            res.send_kind = SEND_BEAT;
            res.send_term = term_r;
          end
        end else begin
          if (elect_left_r != 16'd0) begin
            elect_left_nxt = elect_left_r - 16'd1;
          end
          // Countdown expired: stand as candidate in the next term.
          if (elect_left_nxt == 16'd0) begin
            role_nxt = ROLE_CANDIDATE;
            if (term_r != TERM_TOP) begin
              term_nxt = term_r + 32'd1;
            end
            vote_valid_nxt   = 1'b1;
            vote_node_nxt    = cfg.self_node;
            leader_valid_nxt = 1'b0;
            leader_node_nxt  = 8'd0;
            elect_left_nxt   = timeout;
            votes_nxt        = '0;
            total_nxt        = CNT_W'(1);
            // A lone node wins its own election at once.
            if (majority == CNT_W'(1)) begin
              role_nxt         = ROLE_LEADER;
              leader_valid_nxt = 1'b1;
              leader_node_nxt  = cfg.self_node;
              beat_nxt         = 16'd0;
              res.send_kind    = SEND_BEAT;
            end else begin
              res.send_kind = SEND_VOTE;
            end
            res.send_term = term_nxt;
          end
        end
      end
      REQ_VOTE: begin
        if (item.msg_term > term_r) begin
          role_nxt         = ROLE_FOLLOWER;
          term_nxt         = item.msg_term;
          vote_valid_nxt   = 1'b0;
          vote_node_nxt    = 8'd0;
          leader_valid_nxt = 1'b0;
          leader_node_nxt  = 8'd0;
          elect_left_nxt   = timeout;
        end
        if (item.msg_term == term_nxt &&
            (!vote_valid_nxt || vote_node_nxt == item.sender_node)) begin
          vote_valid_nxt = 1'b1;
          vote_node_nxt  = item.sender_node;
          elect_left_nxt = timeout;
          res.reply_ok   = 1'b1;
        end
        res.reply_kind  = REPLY_VOTE;
        res.answer_term = term_nxt;
      end
      REQ_APPEND: begin
        if (item.msg_term >= term_r) begin
          if (item.msg_term > term_r) begin
            term_nxt       = item.msg_term;
            vote_valid_nxt = 1'b0;
            vote_node_nxt  = 8'd0;
          end
          role_nxt         = ROLE_FOLLOWER;
          leader_valid_nxt = 1'b1;
          leader_node_nxt  = item.sender_node;
          elect_left_nxt   = timeout;
          res.reply_ok     = 1'b1;
        end
        res.reply_kind  = REPLY_APPEND;
        res.answer_term = term_nxt;
      end
      REQ_VOTE_REPLY: begin
        if (role_r == ROLE_CANDIDATE && item.asked_term == term_r) begin
          if (item.msg_term > term_r) begin
            role_nxt         = ROLE_FOLLOWER;
            term_nxt         = item.msg_term;
            vote_valid_nxt   = 1'b0;
            vote_node_nxt    = 8'd0;
            leader_valid_nxt = 1'b0;
            leader_node_nxt  = 8'd0;
            elect_left_nxt   = timeout;
          end else if (item.granted_flag && slot_in_range &&
                       (votes_r & slot_bit) == '0) begin
            // First grant from this peer: count it and check for a win.
            votes_nxt = votes_r | slot_bit;
            total_nxt = total_r + CNT_W'(1);
            if (total_nxt >= majority) begin
              role_nxt         = ROLE_LEADER;
              leader_valid_nxt = 1'b1;
              leader_node_nxt  = cfg.self_node;
              beat_nxt         = 16'd0;
              res.send_kind    = SEND_BEAT;
              res.send_term    = term_r;
            end
          end
        end
      end
      REQ_APPEND_REPLY: begin
        if (role_r == ROLE_LEADER && item.asked_term == term_r &&
            item.msg_term > term_r) begin
          role_nxt         = ROLE_FOLLOWER;
          term_nxt         = item.msg_term;
          vote_valid_nxt   = 1'b0;
          vote_node_nxt    = 8'd0;
          leader_valid_nxt = 1'b0;
          leader_node_nxt  = 8'd0;
          elect_left_nxt   = timeout;
        end
      end
      default: ;
    endcase

    res.node_role    = role_nxt;
    res.term_now     = term_nxt;
    res.leader_known = leader_valid_nxt;
    res.leader_node  = leader_valid_nxt ? leader_node_nxt : 8'd0;
  end

  // Node state, updated once per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r         <= ROLE_FOLLOWER;
      term_r         <= 32'd0;
      vote_valid_r   <= 1'b0;
      vote_node_r    <= 8'd0;
      leader_valid_r <= 1'b0;
      leader_node_r  <= 8'd0;
      elect_left_r   <= 16'd8;
      beat_r         <= 16'd0;
      votes_r        <= '0;
      total_r        <= '0;
    end else if (step) begin
      role_r         <= role_nxt;
      term_r         <= term_nxt;
      vote_valid_r   <= vote_valid_nxt;
      vote_node_r    <= vote_node_nxt;
      leader_valid_r <= leader_valid_nxt;
      leader_node_r  <= leader_node_nxt;
      elect_left_r   <= elect_left_nxt;
      beat_r         <= beat_nxt;
      votes_r        <= votes_nxt;
      total_r        <= total_nxt;
    end
  end

  // A leader always has a known leader.
  a_leader_known: assert property (@(posedge clk) disable iff (!rst_n)
    role_r == ROLE_LEADER |-> leader_valid_r)
    else $error("leader role without a known leader");

  // While a candidate, the vote total is the granted peers plus the own vote.
  a_total_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    role_r == ROLE_CANDIDATE |-> total_r == CNT_W'($countones(votes_r) + 1))
    else $error("vote total out of step with the peer map");

  // A heartbeat is only ever sent by a node that is leader afterwards.
  a_beat_from_leader: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.send_kind == SEND_BEAT |=> role_r == ROLE_LEADER)
    else $error("heartbeat sent by a node that is not leader");

  // A request for votes leaves the node a candidate.
  a_vote_from_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.send_kind == SEND_VOTE |=> role_r == ROLE_CANDIDATE)
    else $error("vote request sent by a node that is not candidate");

endmodule
